FILE: src/bis_pkg.sv
// bis_pkg: opcodes, port widths, default sizes and shared types for bitmap_index_set
// no dependencies

package bis_pkg;

	localparam int OP_W    = 4;
	localparam int INDEX_W = 8;
	localparam int WORD_W  = 64;
	localparam int FOUND_W = 7;

	localparam int DEF_WORD_BITS   = 64;
	localparam int DEF_WORD_COUNT  = 2;
	localparam int DEF_INDEX_LIMIT = 124;

	localparam logic [OP_W-1:0] OP_ADD        = 4'd0;
	localparam logic [OP_W-1:0] OP_REMOVE     = 4'd1;
	localparam logic [OP_W-1:0] OP_EXISTS     = 4'd2;
	localparam logic [OP_W-1:0] OP_CLEAR      = 4'd3;
	localparam logic [OP_W-1:0] OP_FILL       = 4'd4;
	localparam logic [OP_W-1:0] OP_COMPLEMENT = 4'd5;
	localparam logic [OP_W-1:0] OP_UNION      = 4'd6;
	localparam logic [OP_W-1:0] OP_INTERSECT  = 4'd7;
	localparam logic [OP_W-1:0] OP_RELCOMP    = 4'd8;
	localparam logic [OP_W-1:0] OP_EQUALS     = 4'd9;
	localparam logic [OP_W-1:0] OP_LOAD       = 4'd10;
	localparam logic [OP_W-1:0] OP_ITER_RESET = 4'd11;
	localparam logic [OP_W-1:0] OP_ITER_NEXT  = 4'd12;

	typedef struct packed {
		logic bit_on;
		logic word_eq;
		logic first_found;
	} word_flags_t;

endpackage

FILE: src/bis_word_unit.sv
// bis_word_unit: shared per-word unit, applies the request to one set word,
// tests one bit, compares against the operand and finds the lowest set bit
// depends on bis_pkg

module bis_word_unit #(
	parameter int WORD_BITS = bis_pkg::DEF_WORD_BITS,
	parameter int OW        = $clog2(WORD_BITS)
) (
	input  logic [bis_pkg::OP_W-1:0] op,
	input  logic [WORD_BITS-1:0]     cur,
	input  logic [WORD_BITS-1:0]     opw,
	input  logic                     sel,
	input  logic                     bit_sel,
	input  logic [OW-1:0]            bit_off,
	input  logic [WORD_BITS-1:0]     search_mask,
	output logic [WORD_BITS-1:0]     nxt,
	output logic [OW-1:0]            ff_off,
	output bis_pkg::word_flags_t     flags
);
	import bis_pkg::*;

	logic [WORD_BITS-1:0] masked;

	always_comb begin
		nxt = cur;
		unique case (op)
			OP_ADD: begin
				if (bit_sel) nxt[bit_off] = 1'b1;
			end
			OP_REMOVE: begin
				if (bit_sel) nxt[bit_off] = 1'b0;
			end
			OP_CLEAR:      nxt = '0;
			OP_FILL:       nxt = '1;
			OP_COMPLEMENT: nxt = ~cur;
			OP_UNION: begin
				if (sel) nxt = cur | opw;
			end
			OP_INTERSECT: begin
				if (sel) nxt = cur & opw;
			end
			OP_RELCOMP: begin
				if (sel) nxt = cur & ~opw;
			end
			OP_LOAD: begin
				if (sel) nxt = opw;
			end
			default: ;
		endcase
	end

	// lowest set bit at or above the search start
	always_comb begin
		masked = cur & search_mask;
		ff_off = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (masked[i]) ff_off = OW'(i);
		end
	end

	always_comb begin
		flags.bit_on      = cur[bit_off];
		flags.word_eq     = (cur == opw);
		flags.first_found = |masked;
	end

endmodule

FILE: src/bitmap_index_set.sv
// bitmap_index_set: bit set held as WORD_COUNT words with a find-next iterator
// one request sweeps every word through bis_word_unit, one word a cycle, in ST_RUN;
// the result then moves to the output register from ST_PUSH, which waits while the
// output register still holds an untaken result; only after that push does the block
// return to ST_IDLE and take a new request, so requests never overlap in the word unit
// arst_n clears the set to empty, the iterator to zero and both channels to idle
// depends on bis_pkg, bis_word_unit

module bitmap_index_set #(
	parameter int WORD_BITS   = bis_pkg::DEF_WORD_BITS,
	parameter int WORD_COUNT  = bis_pkg::DEF_WORD_COUNT,
	parameter int INDEX_LIMIT = bis_pkg::DEF_INDEX_LIMIT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [bis_pkg::OP_W-1:0]    opcode,
	input  logic [bis_pkg::INDEX_W-1:0] index,
	input  logic                        word_select,
	input  logic [bis_pkg::WORD_W-1:0]  operand_word,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        status,
	output logic                        hit,
	output logic [bis_pkg::FOUND_W-1:0] found_index,
	output logic [bis_pkg::WORD_W-1:0]  word_out,
	output logic                        set_empty,
	output logic                        set_full
);
	import bis_pkg::*;

	localparam int TOTAL_BITS = WORD_BITS * WORD_COUNT;
	localparam int PW = $clog2(TOTAL_BITS + 1);
	localparam int CW = ((PW > INDEX_W) ? PW : INDEX_W) + 1;
	localparam int OW = $clog2(WORD_BITS);
	localparam int WW = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
	localparam int SW = WW + 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_PUSH = 2'd2;

	logic [1:0] state_q;

	logic [WORD_BITS-1:0] words_q [WORD_COUNT];
	logic [PW-1:0]        iter_pos_q;

	logic [OP_W-1:0]      op_q;
	logic [INDEX_W-1:0]   idx_q;
	logic                 ws_q;
	logic [WORD_BITS-1:0] opw_q;
	logic [PW-1:0]        start_q;

	logic [WW-1:0]        w_q;
	logic [PW-1:0]        base_q;

	logic                 status_q;
	logic                 hit_q;
	logic                 found_v_q;
	logic [PW-1:0]        found_pos_q;
	logic [WORD_BITS-1:0] wout_q;
	logic                 empty_q;
	logic                 full_q;

	logic                 out_valid_q;
	logic                 out_status_q;
	logic                 out_hit_q;
	logic [FOUND_W-1:0]   out_found_q;
	logic [WORD_W-1:0]    out_word_q;
	logic                 out_empty_q;
	logic                 out_full_q;

	logic                 accept;
	logic                 push;
	logic                 is_iter;
	logic                 idx_ok;
	logic                 ws_ok;
	logic                 sel;
	logic                 in_word;
	logic                 last_word;
	logic [CW-1:0]        idx_ext;
	logic [CW-1:0]        base_ext;
	logic [CW-1:0]        base_end;
	logic [CW-1:0]        start_ext;
	logic [CW-1:0]        idx_rel;
	logic [CW-1:0]        start_rel;
	logic [CW-1:0]        found_ext;
	logic [WORD_BITS-1:0] cur;
	logic [WORD_BITS-1:0] nxt;
	logic [WORD_BITS-1:0] search_mask;
	logic [OW-1:0]        ff_off;
	word_flags_t          flags;

	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign push      = (state_q == ST_PUSH) && (!out_valid_q || out_ready);
	assign is_iter   = (op_q == OP_ITER_RESET) || (op_q == OP_ITER_NEXT);

	assign idx_ext   = CW'(idx_q);
	assign base_ext  = CW'(base_q);
	assign base_end  = base_ext + CW'(WORD_BITS);
	assign start_ext = CW'(start_q);
	assign idx_rel   = idx_ext - base_ext;
	assign start_rel = start_ext - base_ext;
	assign found_ext = CW'(found_pos_q);

	assign idx_ok    = (idx_ext < CW'(INDEX_LIMIT)) && (idx_ext < CW'(TOTAL_BITS));
	assign ws_ok     = SW'(ws_q) < SW'(WORD_COUNT);
	assign sel       = ws_ok && (SW'(ws_q) == SW'(w_q));
	assign in_word   = idx_ok && (idx_ext >= base_ext) && (idx_ext < base_end);
	assign last_word = (w_q == WW'(WORD_COUNT - 1));
	assign cur       = words_q[w_q];

	always_comb begin
		if (start_ext <= base_ext) begin
			search_mask = '1;
		end else if (start_ext >= base_end) begin
			search_mask = '0;
		end else begin
			search_mask = {WORD_BITS{1'b1}} << start_rel[OW-1:0];
		end
	end

	bis_word_unit #(
		.WORD_BITS(WORD_BITS),
		.OW(OW)
	) u_word (
		.op(op_q),
		.cur(cur),
		.opw(opw_q),
		.sel(sel),
		.bit_sel(in_word),
		.bit_off(idx_rel[OW-1:0]),
		.search_mask(search_mask),
		.nxt(nxt),
		.ff_off(ff_off),
		.flags(flags)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			w_q     <= '0;
			base_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_RUN;
						w_q     <= '0;
						base_q  <= '0;
					end
				end
				ST_RUN: begin
					if (last_word) begin
						state_q <= ST_PUSH;
					end else begin
						w_q    <= w_q + 1'b1;
						base_q <= base_q + PW'(WORD_BITS);
					end
				end
				ST_PUSH: begin
					if (push) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= opcode;
			idx_q   <= index;
			ws_q    <= word_select;
			opw_q   <= operand_word[WORD_BITS-1:0];
			start_q <= (opcode == OP_ITER_RESET) ? '0 : iter_pos_q;
		end
	end

	// set storage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WORD_COUNT; i++) words_q[i] <= '0;
		end else if (state_q == ST_RUN) begin
			words_q[w_q] <= nxt;
		end
	end

	// per-request accumulators
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q    <= 1'b0;
			hit_q       <= 1'b0;
			found_v_q   <= 1'b0;
			found_pos_q <= '0;
			wout_q      <= '0;
			empty_q     <= 1'b1;
			full_q      <= 1'b1;
		end else if (state_q == ST_RUN) begin
			if ((op_q == OP_ADD || op_q == OP_REMOVE) && !idx_ok) status_q <= 1'b1;
			if (op_q == OP_EXISTS && in_word && flags.bit_on) hit_q <= 1'b1;
			if (op_q == OP_EQUALS && sel && flags.word_eq) hit_q <= 1'b1;
			if (is_iter && !found_v_q && flags.first_found) begin
				found_v_q   <= 1'b1;
				found_pos_q <= base_q + PW'(ff_off);
			end
			if (sel) wout_q <= nxt;
			if (nxt != '0) empty_q <= 1'b0;
			if (nxt != '1) full_q <= 1'b0;
		end
	end

	// iterator position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_pos_q <= '0;
		end else if (push) begin
			if (op_q == OP_ITER_RESET) begin
				iter_pos_q <= '0;
			end else if (op_q == OP_ITER_NEXT) begin
				iter_pos_q <= found_v_q ? found_pos_q + 1'b1 : PW'(TOTAL_BITS);
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_status_q <= status_q;
			out_hit_q    <= is_iter ? found_v_q : hit_q;
			out_found_q  <= found_ext[FOUND_W-1:0];
			out_word_q   <= WORD_W'(wout_q);
			out_empty_q  <= empty_q;
			out_full_q   <= full_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign hit         = out_hit_q;
	assign found_index = out_found_q;
	assign word_out    = out_word_q;
	assign set_empty   = out_empty_q;
	assign set_full    = out_full_q;

endmodule

FILE: dv/bitmap_index_set_tb.sv
// bitmap_index_set_tb: self-checking bench for the bitmap set block with its find-next iterator
// a clocked driver and monitor with random idling, checked against an in-bench copy of the set
// depends on bis_pkg and bitmap_index_set

module bitmap_index_set_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bis_pkg::*;

	localparam int WORD_BITS   = DEF_WORD_BITS;
	localparam int WORD_COUNT  = DEF_WORD_COUNT;
	localparam int INDEX_LIMIT = DEF_INDEX_LIMIT;
	localparam int TOTAL_BITS  = WORD_BITS * WORD_COUNT;
	localparam int RANDOM_REQS = 1100;

	typedef struct {
		logic [OP_W-1:0]    opcode;
		logic [INDEX_W-1:0] index;
		logic               word_select;
		logic [WORD_W-1:0]  operand_word;
	} request_t;

	typedef struct {
		logic               status;
		logic               hit;
		logic [FOUND_W-1:0] found_index;
		logic [WORD_W-1:0]  word_out;
		logic               set_empty;
		logic               set_full;
	} answer_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [OP_W-1:0]     opcode = '0;
	logic [INDEX_W-1:0]  index = '0;
	logic                word_select = 1'b0;
	logic [WORD_W-1:0]   operand_word = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic                status;
	logic                hit;
	logic [FOUND_W-1:0]  found_index;
	logic [WORD_W-1:0]   word_out;
	logic                set_empty;
	logic                set_full;

	request_t            request_q[$];
	answer_t             answer_q[$];
	request_t            cur_req;
	answer_t             mon_want;
	logic                drv_busy;

	logic [TOTAL_BITS-1:0] members = '0;
	logic [7:0]            iter_pos = '0;

	int errors = 0;
	int n_sent = 0;
	int n_hits = 0;
	int n_range_errs = 0;
	int n_iter_finds = 0;
	int idle_pct;
	int stall_pct;
	logic [15:0] ops_seen = '0;

	bitmap_index_set u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.index(index),
		.word_select(word_select),
		.operand_word(operand_word),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.hit(hit),
		.found_index(found_index),
		.word_out(word_out),
		.set_empty(set_empty),
		.set_full(set_full)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic logic lowest_from(input int start, output int pos);
		pos = 0;
		for (int p = start; p < TOTAL_BITS; p++) begin
			if (members[p]) begin
				pos = p;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic answer_t bitmap_apply(input request_t r);
		answer_t res;
		int base;
		int f;
		logic idx_ok;
		res = '{default: '0};
		base = r.word_select * WORD_BITS;
		idx_ok = (r.index < INDEX_LIMIT) && (r.index < TOTAL_BITS);
		ops_seen[r.opcode] = 1'b1;
		case (r.opcode)
			OP_ADD, OP_REMOVE: begin
				if (!idx_ok)
					res.status = 1'b1;
				else
					members[r.index[6:0]] = (r.opcode == OP_ADD);
			end
			OP_EXISTS: res.hit = idx_ok && members[r.index[6:0]];
			OP_CLEAR: members = '0;
			OP_FILL: members = '1;
			OP_COMPLEMENT: members = ~members;
			OP_UNION: members[base +: WORD_BITS] = members[base +: WORD_BITS] | r.operand_word;
			OP_INTERSECT: members[base +: WORD_BITS] = members[base +: WORD_BITS] & r.operand_word;
			OP_RELCOMP: members[base +: WORD_BITS] = members[base +: WORD_BITS] & ~r.operand_word;
			OP_EQUALS: res.hit = (members[base +: WORD_BITS] == r.operand_word);
			OP_LOAD: members[base +: WORD_BITS] = r.operand_word;
			OP_ITER_RESET: begin
				iter_pos = '0;
				if (lowest_from(0, f)) begin
					res.hit = 1'b1;
					res.found_index = f[FOUND_W-1:0];
				end
			end
			OP_ITER_NEXT: begin
				if (iter_pos < TOTAL_BITS && lowest_from(int'(iter_pos), f)) begin
					res.hit = 1'b1;
					res.found_index = f[FOUND_W-1:0];
					iter_pos = 8'(f + 1);
				end else begin
					iter_pos = 8'(TOTAL_BITS);
				end
			end
			default: ;
		endcase
		res.word_out = members[base +: WORD_BITS];
		res.set_empty = (members == '0);
		res.set_full = &members;
		n_hits += res.hit;
		n_range_errs += res.status;
		if (res.hit && (r.opcode == OP_ITER_RESET || r.opcode == OP_ITER_NEXT))
			n_iter_finds++;
		return res;
	endfunction

	function automatic void push_req(input logic [OP_W-1:0] op, input logic [INDEX_W-1:0] idx,
			input logic ws, input logic [WORD_W-1:0] w);
		request_t r;
		r.opcode = op;
		r.index = idx;
		r.word_select = ws;
		r.operand_word = w;
		request_q.push_back(r);
	endfunction

	function automatic logic [INDEX_W-1:0] rand_index();
		int r;
		logic [INDEX_W-1:0] edges[8];
		edges = '{8'd0, 8'd63, 8'd64, 8'd123, 8'd124, 8'd127, 8'd128, 8'd255};
		r = $urandom_range(0, 99);
		if (r < 10)
			return INDEX_W'($urandom_range(124, 255));
		if (r < 20)
			return edges[$urandom_range(0, 7)];
		return INDEX_W'($urandom_range(0, INDEX_LIMIT - 1));
	endfunction

	function automatic logic [WORD_W-1:0] rand_word();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return '0;
		if (r < 20)
			return '1;
		if (r < 30)
			return 64'd1 << $urandom_range(0, 63);
		return {$urandom, $urandom};
	endfunction

	always_comb begin
		if (n_sent < RANDOM_REQS / 3) begin
			idle_pct = 14;
			stall_pct = 56;
		end else if (n_sent < 2 * RANDOM_REQS / 3) begin
			idle_pct = 56;
			stall_pct = 14;
		end else begin
			idle_pct = 0;
			stall_pct = 0;
		end
	end

	// driver: predicts at acceptance, then offers the next pending request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			drv_busy = in_valid;
			if (in_valid && in_ready) begin
				answer_q.push_back(bitmap_apply(cur_req));
				n_sent++;
				drv_busy = 1'b0;
			end
			if (!drv_busy) begin
				if (request_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
					cur_req = request_q.pop_front();
					opcode <= cur_req.opcode;
					index <= cur_req.index;
					word_select <= cur_req.word_select;
					operand_word <= cur_req.operand_word;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t mismatch %s: expected %h, actual %h", $time, name, want, got);
		end
	endtask

	// monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (answer_q.size() == 0) begin
				errors++;
				$display("%0t unexpected result: expected none, actual word_out %h", $time,
					word_out);
			end else begin
				mon_want = answer_q.pop_front();
				check_field("status", 64'(mon_want.status), 64'(status));
				check_field("hit", 64'(mon_want.hit), 64'(hit));
				check_field("found_index", 64'(mon_want.found_index), 64'(found_index));
				check_field("word_out", mon_want.word_out, word_out);
				check_field("set_empty", 64'(mon_want.set_empty), 64'(set_empty));
				check_field("set_full", 64'(mon_want.set_full), 64'(set_full));
			end
		end
	end

	initial begin
		int kind;
		int n;
		logic ws;
		logic [WORD_W-1:0] w;

		// directed: range edges, whole-set ops, word ops, iterator ends, unused codes
		push_req(OP_ADD, 8'd0, 1'b0, '0);
		push_req(OP_ADD, 8'd123, 1'b1, '0);
		push_req(OP_ADD, 8'd124, 1'b1, '0);
		push_req(OP_ADD, 8'd255, 1'b1, '1);
		push_req(OP_EXISTS, 8'd123, 1'b1, '0);
		push_req(OP_EXISTS, 8'd124, 1'b1, '0);
		push_req(OP_REMOVE, 8'd123, 1'b1, '0);
		push_req(OP_REMOVE, 8'd200, 1'b0, '0);
		push_req(OP_ITER_RESET, 8'd0, 1'b0, '0);
		push_req(OP_ITER_NEXT, 8'd0, 1'b0, '0);
		push_req(OP_ITER_NEXT, 8'd0, 1'b0, '0);
		push_req(OP_ITER_NEXT, 8'd0, 1'b1, '0);
		push_req(OP_FILL, 8'd0, 1'b1, '0);
		push_req(OP_EXISTS, 8'd127, 1'b1, '0);
		push_req(OP_REMOVE, 8'd127, 1'b1, '0);
		push_req(OP_COMPLEMENT, 8'd0, 1'b0, '0);
		push_req(OP_LOAD, 8'd0, 1'b1, 64'h8000_0000_0000_0001);
		push_req(OP_EQUALS, 8'd0, 1'b1, 64'h8000_0000_0000_0001);
		push_req(OP_EQUALS, 8'd0, 1'b0, '1);
		push_req(OP_UNION, 8'd0, 1'b0, '1);
		push_req(OP_INTERSECT, 8'd0, 1'b0, 64'h5555_5555_5555_5555);
		push_req(OP_RELCOMP, 8'd0, 1'b1, 64'h1);
		push_req(OP_CLEAR, 8'd0, 1'b0, '0);
		push_req(OP_ITER_RESET, 8'd0, 1'b1, '0);
		push_req(4'd13, 8'd5, 1'b0, '1);
		push_req(4'd15, 8'd255, 1'b1, '1);

		while (request_q.size() < RANDOM_REQS + 26) begin
			kind = $urandom_range(0, 99);
			ws = 1'($urandom_range(0, 1));
			if (kind < 30) begin
				push_req(OP_W'($urandom_range(0, 15)), rand_index(), ws, rand_word());
			end else if (kind < 50) begin
				n = $urandom_range(2, 8);
				repeat (n)
					push_req(OP_W'($urandom_range(OP_ADD, OP_EXISTS)), rand_index(), ws,
						rand_word());
			end else if (kind < 65) begin
				w = rand_word();
				push_req(OP_LOAD, rand_index(), ws, w);
				if ($urandom_range(0, 1))
					push_req(OP_W'($urandom_range(OP_ADD, OP_EXISTS)), rand_index(),
						1'($urandom_range(0, 1)), rand_word());
				push_req(OP_EQUALS, rand_index(), ws, w);
				push_req(OP_EQUALS, rand_index(), ws, w ^ (64'd1 << $urandom_range(0, 63)));
			end else if (kind < 85) begin
				if ($urandom_range(0, 1)) begin
					push_req(OP_CLEAR, rand_index(), ws, rand_word());
					repeat ($urandom_range(0, 5))
						push_req(OP_ADD, INDEX_W'($urandom_range(0, INDEX_LIMIT - 1)), ws,
							rand_word());
					if ($urandom_range(0, 3) == 0)
						push_req(OP_UNION, rand_index(), 1'b1, 64'd1 << $urandom_range(60, 63));
				end
				push_req(OP_ITER_RESET, rand_index(), ws, rand_word());
				repeat ($urandom_range(1, 10))
					push_req(OP_ITER_NEXT, rand_index(), 1'($urandom_range(0, 1)), rand_word());
			end else begin
				n = $urandom_range(1, 4);
				repeat (n)
					push_req(OP_W'($urandom_range(OP_CLEAR, OP_LOAD)), rand_index(),
						1'($urandom_range(0, 1)), rand_word());
			end
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (request_q.size() > 0 || in_valid || answer_q.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("covered %0d requests over %0d of 16 opcode values under three idling mixes",
			n_sent, $countones(ops_seen));
		$display("saw %0d hits, %0d range errors, %0d iterator finds", n_hits, n_range_errs,
			n_iter_finds);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

FILE: bitmap_index_set.f
src/bis_pkg.sv
src/bis_word_unit.sv
src/bitmap_index_set.sv
dv/bitmap_index_set_tb.sv
